FILE: rtl/trapi_pkg.sv
// ----------------------------------------------------------------------------
// trapi_pkg: shared types and constants of the trapezoid integrator
// Fixed-point formats, payload structs, sequencer states and the rounding
// helper used by the polynomial pipeline and the top level.
// ----------------------------------------------------------------------------
package trapi_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int STEP_FRAC     = 32;
  localparam int XSH           = STEP_FRAC - FRAC_BITS;
  localparam int MAX_INTERVALS = 1048576;

  localparam int LIM_W = 20;
  localparam int CNT_W = 21;
  localparam int OUT_W = 35;

  // Widths inside the Horner pipeline, sized for |x| < 8.
  localparam int P1_W = 22;
  localparam int M1_W = 42;
  localparam int P2_W = 26;
  localparam int M2_W = 46;
  localparam int P3_W = 30;
  localparam int M3_W = 50;
  localparam int F_W  = 34;

  localparam int ONE = 1 << FRAC_BITS;

  typedef struct packed {
    logic signed [LIM_W-1:0] lower_limit;
    logic signed [LIM_W-1:0] upper_limit;
    logic [CNT_W-1:0]        interval_count;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] integral;
    logic                    count_error;
  } out_t;

  typedef struct packed {
    logic                    vld;
    logic                    endpt;
    logic signed [LIM_W-1:0] x;
  } poly_req_t;

  typedef struct packed {
    logic                  vld;
    logic                  endpt;
    logic                  busy;
    logic signed [F_W-1:0] f;
  } poly_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_FEED_A,
    S_FEED_B,
    S_FEED_PTS,
    S_DRAIN,
    S_SCALE,
    S_ROUND,
    S_FINISH
  } state_e;

  // Arithmetic right shift by sh with round to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic signed [63:0] bias;
    logic signed [63:0] t;
    bias = (64'sd1 <<< (sh - 1)) - (v[63] ? 64'sd1 : 64'sd0);
    t    = v + bias;
    return t >>> sh;
  endfunction

endpackage

FILE: rtl/trapi_poly.sv
// ----------------------------------------------------------------------------
// trapi_poly: pipelined evaluator of x^4 - 3x^3 + 2x^2 - x + 5
// Horner scheme in seven stages, one point per cycle, each product rounded
// back to the working fraction before the next multiplication.
// ----------------------------------------------------------------------------
module trapi_poly (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  trapi_pkg::poly_req_t  req_i,
  output trapi_pkg::poly_rsp_t  rsp_o
);
  import trapi_pkg::*;

  logic [6:0] v_q;
  logic [6:0] e_q;

  logic signed [LIM_W-1:0] x1_q, x2_q, x3_q, x4_q, x5_q;
  logic signed [P1_W-1:0]  p1_q;
  logic signed [M1_W-1:0]  m1_q;
  logic signed [P2_W-1:0]  p2_q;
  logic signed [M2_W-1:0]  m2_q;
  logic signed [P3_W-1:0]  p3_q;
  logic signed [M3_W-1:0]  m3_q;
  logic signed [F_W-1:0]   f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[5:0], req_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    e_q  <= {e_q[5:0], req_i.endpt};
    x1_q <= req_i.x;
    p1_q <= P1_W'(req_i.x) - P1_W'(3 * ONE);
    m1_q <= p1_q * x1_q;
    x2_q <= x1_q;
    p2_q <= P2_W'(rnd_shift(64'(m1_q), FRAC_BITS)) + P2_W'(2 * ONE);
    x3_q <= x2_q;
    m2_q <= p2_q * x3_q;
    x4_q <= x3_q;
    p3_q <= P3_W'(rnd_shift(64'(m2_q), FRAC_BITS)) - P3_W'(ONE);
    x5_q <= x4_q;
    m3_q <= p3_q * x5_q;
    f_q  <= F_W'(rnd_shift(64'(m3_q), FRAC_BITS)) + F_W'(5 * ONE);
  end

  assign rsp_o.vld   = v_q[6];
  assign rsp_o.endpt = e_q[6];
  assign rsp_o.busy  = |v_q;
  assign rsp_o.f     = f_q;

endmodule

FILE: rtl/trapezoid_poly_integrator_unit.sv
// ----------------------------------------------------------------------------
// trapezoid_poly_integrator_unit: trapezoidal integral of a fixed quartic
// Integrates x^4 - 3x^3 + 2x^2 - x + 5 between two Q4.16 limits over a given
// number of intervals and returns a saturated Q19.16 result.
// ----------------------------------------------------------------------------
// Usage: present lower limit, upper limit and interval count on in_data_i with
// in_valid_i; the transfer happens when in_stall_o is low. The block holds
// in_stall_o high while it works on that item, so it handles one item at a
// time. One result per item leaves on out_data_o with out_valid_o.
// For a count n (clamped to 2^20) the work after the input transfer runs in
// this order: the bit-serial step divider, the two end points, the interior
// points issued into the seven-stage polynomial pipeline, the pipeline drain,
// the four partial products of the final scaling multiply, one rounding step
// and the hand-off to the output register. The next input is taken only once
// the block is back in idle after that hand-off. A zero count is answered
// with count_error set. The points stream at one per cycle.
// Reset clears the sequencer and the output valid; no result is pending.
// A stalled result stays in the output register while the next item is
// already accepted and worked on; only the hand-off of that next result
// waits until the receiver has taken the older one.
// ----------------------------------------------------------------------------
module trapezoid_poly_integrator_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  trapi_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output trapi_pkg::out_t out_data_o
);
  import trapi_pkg::*;

  localparam int DIV_N = CNT_W + XSH;       // quotient bits of the step
  localparam int DCW   = $clog2(DIV_N + 1);
  localparam int H_W   = DIV_N + 1;
  localparam int X32_W = 40;
  localparam int SUM_W = 53;
  localparam int ALO_W = 27;                // low chunk of |sum|
  localparam int AHI_W = SUM_W - ALO_W;
  localparam int BLO_W = 19;                // low chunk of |h|
  localparam int BHI_W = DIV_N - BLO_W;
  localparam int PP_W  = ALO_W + BLO_W;
  localparam int ACC_W = SUM_W + DIV_N;
  localparam int Q_W   = ACC_W - (STEP_FRAC + 1);

  state_e state_q, state_d;

  logic signed [LIM_W-1:0] a_q, b_q;
  logic [CNT_W-1:0]        nc_q;
  logic                    dneg_q;
  logic [DIV_N-1:0]        dv_q;
  logic [CNT_W-1:0]        rem_q;
  logic [DCW-1:0]          dcnt_q;
  logic signed [H_W-1:0]   h_q;
  logic signed [X32_W-1:0] x32_q;
  logic [CNT_W-1:0]        pts_q;
  logic signed [SUM_W-1:0] int_sum_q, end_sum_q;
  logic [SUM_W-1:0]        sm_q;
  logic                    sneg_q;
  logic [2:0]              k_q;
  logic [1:0]              ppk_q;
  logic [PP_W-1:0]         pp_q;
  logic [ACC_W-1:0]        acc_q;
  out_t                    res_q;
  out_t                    out_q;
  logic                    out_valid_q;

  poly_req_t poly_req;
  poly_rsp_t poly_rsp;

  trapi_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (poly_req),
    .rsp_o  (poly_rsp)
  );

  // Input decode: limit difference, its magnitude and the clamped count.
  logic signed [CNT_W-1:0] diff;
  logic [CNT_W-1:0]        diff_mag;
  logic [CNT_W-1:0]        n_clamp;
  assign diff     = CNT_W'(in_data_i.upper_limit) - CNT_W'(in_data_i.lower_limit);
  assign diff_mag = diff[CNT_W-1] ? CNT_W'(-diff) : CNT_W'(diff);
  assign n_clamp  = (in_data_i.interval_count > CNT_W'(MAX_INTERVALS)) ?
                    CNT_W'(MAX_INTERVALS) : in_data_i.interval_count;

  // One restoring division step per cycle.
  logic [CNT_W:0] rem_sh;
  logic           rem_ge;
  assign rem_sh = {rem_q, dv_q[DIV_N-1]};
  assign rem_ge = rem_sh >= {1'b0, nc_q};

  // Current sample point, rounded from the 32-fraction-bit position.
  logic signed [LIM_W-1:0] x_pt;
  logic signed [X32_W-1:0] a32;
  assign x_pt = LIM_W'(rnd_shift(64'(x32_q), XSH));
  assign a32  = X32_W'(a_q) <<< XSH;

  // Doubled trapezoid sum: interior points twice, end points once.
  logic signed [SUM_W-1:0] sum_total;
  assign sum_total = (int_sum_q <<< 1) + end_sum_q;

  // Shared partial-product multiplier of the final scaling.
  logic [ALO_W-1:0] a_chunk;
  logic [BLO_W-1:0] b_chunk;
  logic [PP_W-1:0]  pp_d;
  logic [ACC_W-1:0] pp_shifted;
  assign a_chunk = k_q[0] ? ALO_W'(sm_q[ALO_W +: AHI_W]) : sm_q[ALO_W-1:0];
  assign b_chunk = k_q[1] ? BLO_W'(dv_q[BLO_W +: BHI_W]) : dv_q[BLO_W-1:0];
  assign pp_d    = PP_W'(a_chunk) * PP_W'(b_chunk);

  always_comb begin
    case (ppk_q)
      2'd0:    pp_shifted = ACC_W'(pp_q);
      2'd1:    pp_shifted = ACC_W'(pp_q) << ALO_W;
      2'd2:    pp_shifted = ACC_W'(pp_q) << BLO_W;
      default: pp_shifted = ACC_W'(pp_q) << (ALO_W + BLO_W);
    endcase
  end

  // Rounding of the scaled product to the output format with saturation.
  // The product carries 33 extra fraction bits: 32 of the step, one for the halving.
  logic [ACC_W-1:0]        acc_rnd;
  logic [Q_W-1:0]          q_mag;
  logic                    res_neg;
  logic signed [OUT_W-1:0] res_val;
  assign acc_rnd = acc_q + (ACC_W'(1) << STEP_FRAC);
  assign q_mag   = acc_rnd[ACC_W-1:STEP_FRAC+1];
  assign res_neg = sneg_q ^ dneg_q;

  always_comb begin
    if (res_neg) begin
      if (q_mag > (Q_W'(1) << (OUT_W - 1))) begin
        res_val = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        res_val = OUT_W'(-q_mag);
      end
    end else begin
      if (q_mag > Q_W'({1'b0, {(OUT_W-1){1'b1}}})) begin
        res_val = {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
        res_val = OUT_W'(q_mag);
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d        = state_q;
    in_stall_o     = 1'b1;
    poly_req.vld   = 1'b0;
    poly_req.endpt = 1'b0;
    poly_req.x     = x_pt;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = (in_data_i.interval_count == '0) ? S_FINISH : S_DIV;
        end
      end
      S_DIV: begin
        if (dcnt_q == DCW'(DIV_N - 1)) begin
          state_d = S_FEED_A;
        end
      end
      S_FEED_A: begin
        poly_req.vld   = 1'b1;
        poly_req.endpt = 1'b1;
        poly_req.x     = a_q;
        state_d        = S_FEED_B;
      end
      S_FEED_B: begin
        poly_req.vld   = 1'b1;
        poly_req.endpt = 1'b1;
        poly_req.x     = b_q;
        state_d        = S_FEED_PTS;
      end
      S_FEED_PTS: begin
        if (pts_q == '0) begin
          state_d = S_DRAIN;
        end else begin
          poly_req.vld = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!poly_rsp.busy) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        if (k_q == 3'd4) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FINISH && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (poly_rsp.vld) begin
      if (poly_rsp.endpt) begin
        end_sum_q <= end_sum_q + SUM_W'(poly_rsp.f);
      end else begin
        int_sum_q <= int_sum_q + SUM_W'(poly_rsp.f);
      end
    end
    case (state_q)
      S_IDLE: begin
        a_q       <= in_data_i.lower_limit;
        b_q       <= in_data_i.upper_limit;
        nc_q      <= n_clamp;
        dneg_q    <= diff[CNT_W-1];
        dv_q      <= {diff_mag, {XSH{1'b0}}};
        rem_q     <= '0;
        dcnt_q    <= '0;
        int_sum_q <= '0;
        end_sum_q <= '0;
        res_q     <= '{integral: '0, count_error: 1'b1};
      end
      S_DIV: begin
        rem_q  <= rem_ge ? CNT_W'(rem_sh - {1'b0, nc_q}) : CNT_W'(rem_sh);
        dv_q   <= {dv_q[DIV_N-2:0], rem_ge};
        dcnt_q <= dcnt_q + DCW'(1);
      end
      S_FEED_A: begin
        h_q   <= dneg_q ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});
        pts_q <= nc_q - CNT_W'(1);
      end
      S_FEED_B: begin
        x32_q <= a32 + X32_W'(h_q);
      end
      S_FEED_PTS: begin
        if (pts_q != '0) begin
          x32_q <= x32_q + X32_W'(h_q);
          pts_q <= pts_q - CNT_W'(1);
        end
      end
      S_DRAIN: begin
        sm_q   <= sum_total[SUM_W-1] ? SUM_W'(-sum_total) : SUM_W'(sum_total);
        sneg_q <= sum_total[SUM_W-1];
        acc_q  <= '0;
        k_q    <= '0;
      end
      S_SCALE: begin
        // Step k multiplies chunk pair k and adds the product of step k-1.
        if (k_q != 3'd4) begin
          pp_q  <= pp_d;
          ppk_q <= k_q[1:0];
        end
        if (k_q != 3'd0) begin
          acc_q <= acc_q + pp_shifted;
        end
        k_q <= k_q + 3'd1;
      end
      S_ROUND: begin
        res_q <= '{integral: res_val, count_error: 1'b0};
      end
      default: begin
      end
    endcase
    if (state_q == S_FINISH && (!out_valid_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
